### rtl/core/ptct_pkg.sv
// shared types and constants for the port traffic counter table
// no dependencies
`default_nettype none
package ptct_pkg;

    localparam int TABLE_ENTRIES = 4096;
    localparam int SLOT_W        = $clog2(TABLE_ENTRIES);
    localparam int KEY_W         = 17;
    localparam int KEY_SPACE     = 1 << KEY_W;
    localparam int CNT_W         = 13;
    localparam int CTR_W         = 64;

    localparam logic [7:0] IPPROTO_NUM_TCP = 8'd6;
    localparam logic [7:0] IPPROTO_NUM_UDP = 8'd17;
    localparam logic       XPORT_TCP       = 1'b0;
    localparam logic       XPORT_UDP       = 1'b1;
    localparam logic       OP_PACKET       = 1'b0;
    localparam logic       OP_QUERY        = 1'b1;

    localparam logic [CNT_W-1:0] LIMIT_MAX = CNT_W'(TABLE_ENTRIES);

    typedef struct packed {
        logic [KEY_W-1:0] key;
        logic [CTR_W-1:0] pkts;
        logic [CTR_W-1:0] bytes;
    } entry_t;

endpackage
`default_nettype wire

### rtl/core/ptct_map_ram.sv
// key to slot map, one synchronous read port and one write port
// depends on ptct_pkg
`default_nettype none
module ptct_map_ram
    import ptct_pkg::*;
(
    input  wire logic              aclk,
    input  wire logic [KEY_W-1:0]  rd_addr,
    output logic      [SLOT_W-1:0] rd_data,
    input  wire logic              wr_en,
    input  wire logic [KEY_W-1:0]  wr_addr,
    input  wire logic [SLOT_W-1:0] wr_data
);
    logic [SLOT_W-1:0] mem [KEY_SPACE];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end
endmodule
`default_nettype wire

### rtl/core/ptct_entry_ram.sv
// slot storage: key and both counters, one synchronous read and one write port
// depends on ptct_pkg
`default_nettype none
module ptct_entry_ram
    import ptct_pkg::*;
(
    input  wire logic              aclk,
    input  wire logic [SLOT_W-1:0] rd_addr,
    output entry_t                 rd_data,
    input  wire logic              wr_en,
    input  wire logic [SLOT_W-1:0] wr_addr,
    input  wire entry_t            wr_data
);
    entry_t mem [TABLE_ENTRIES];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end
endmodule
`default_nettype wire

### rtl/core/port_traffic_counter_table_core.sv
// top level of the per-port packet and byte counter table
// depends on ptct_pkg, ptct_map_ram and ptct_entry_ram
`default_nettype none
// One request per packet header or per query. A packet event is accepted,
// then each looked-up key passes map read, entry read and update (the
// destination port first, then the source port when the two differ), and
// a done state posts the result; a query looks up one key, an ignored
// packet goes straight to done. Each key takes two chained synchronous
// memory reads: the key-to-slot map and then the slot entry. Slots are
// handed out densely; a map entry is trusted only when its slot is below
// the fill count and the slot stores the same key, so neither memory needs
// clearing after reset. The result sits in an output register, and a new
// request is taken while the previous result still waits.
module port_traffic_counter_table_core
    import ptct_pkg::*;
(
    input  wire logic              aclk,
    input  wire logic              aresetn,
    // configuration: entry limit
    input  wire logic              cfg_valid,
    output logic                   cfg_ready,
    input  wire logic [CNT_W-1:0]  cfg_data,
    // request channel
    input  wire logic              s_valid,
    output logic                   s_ready,
    input  wire logic              s_op,
    input  wire logic [7:0]        s_ip_protocol,
    input  wire logic              s_header_present,
    input  wire logic [15:0]       s_total_length,
    input  wire logic [15:0]       s_source_port,
    input  wire logic [15:0]       s_destination_port,
    input  wire logic              s_query_is_udp,
    input  wire logic [15:0]       s_query_port,
    // result channel
    output logic                   m_valid,
    input  wire logic              m_ready,
    output logic                   m_packet_counted,
    output logic                   m_destination_dropped,
    output logic                   m_source_dropped,
    output logic      [CNT_W-1:0]  m_entries_in_use,
    output logic                   m_entry_found,
    output logic      [CTR_W-1:0]  m_entry_packets,
    output logic      [CTR_W-1:0]  m_entry_bytes,
    output logic      [CTR_W-1:0]  m_all_packets,
    output logic      [CTR_W-1:0]  m_all_bytes
);

    typedef enum logic [4:0] {
        ST_IDLE   = 5'b00001,
        ST_MAP_RD = 5'b00010,
        ST_ENT_RD = 5'b00100,
        ST_UPDATE = 5'b01000,
        ST_DONE   = 5'b10000
    } state_t;

    state_t            state_reg, state_next;
    logic [CNT_W-1:0]  limit_reg;
    logic [CNT_W-1:0]  alloc_reg;
    logic [CTR_W-1:0]  gpkts_reg, gbytes_reg;
    logic              m_valid_reg;

    // per-request working registers
    logic              is_query_reg;
    logic              src_pending_reg;
    logic [KEY_W-1:0]  cur_key_reg;
    logic [KEY_W-1:0]  src_key_reg;
    logic [15:0]       len_reg;
    logic              counted_reg, ddrop_reg, sdrop_reg, src_phase_reg;
    logic              found_reg;
    logic [CTR_W-1:0]  epk_reg, eby_reg;

    // memory ports
    logic [SLOT_W-1:0] map_rd_data;
    logic              map_wr_en;
    entry_t            ent_rd_data, ent_wr_data;
    logic              ent_wr_en;
    logic [SLOT_W-1:0] ent_wr_addr;

    logic              accept;
    logic              counted_in, tr_in;
    logic [CNT_W-1:0]  eff_limit;
    logic              hit, can_alloc, drop_now;

    assign cfg_ready = 1'b1;
    assign s_ready   = (state_reg == ST_IDLE);
    assign accept    = s_valid && s_ready;
    assign m_valid   = m_valid_reg;

    // effective limit never exceeds the table size
    assign eff_limit = (limit_reg > LIMIT_MAX) ? LIMIT_MAX : limit_reg;

    assign counted_in = (s_op == OP_PACKET) && s_header_present &&
                        ((s_ip_protocol == IPPROTO_NUM_TCP) ||
                         (s_ip_protocol == IPPROTO_NUM_UDP));
    assign tr_in = (s_ip_protocol == IPPROTO_NUM_TCP) ? XPORT_TCP : XPORT_UDP;

    // stored slot is valid only if below fill count and holding this key
    always_comb begin
        hit = 1'b0;
        if ({1'b0, map_rd_data} < alloc_reg) begin
            if (ent_rd_data.key == cur_key_reg) begin
                hit = 1'b1;
            end
        end
    end
    assign can_alloc = (alloc_reg < eff_limit);

    ptct_map_ram u_map (
        .aclk    (aclk),
        .rd_addr (cur_key_reg),
        .rd_data (map_rd_data),
        .wr_en   (map_wr_en),
        .wr_addr (cur_key_reg),
        .wr_data (alloc_reg[SLOT_W-1:0])
    );

    ptct_entry_ram u_entries (
        .aclk    (aclk),
        .rd_addr (map_rd_data),
        .rd_data (ent_rd_data),
        .wr_en   (ent_wr_en),
        .wr_addr (ent_wr_addr),
        .wr_data (ent_wr_data)
    );

    // packet update step: bump a hit entry, else allocate a fresh slot if room, else drop
    always_comb begin
        map_wr_en   = 1'b0;
        ent_wr_en   = 1'b0;
        ent_wr_addr = map_rd_data;
        drop_now    = 1'b0;
        ent_wr_data.key   = cur_key_reg;
        ent_wr_data.pkts  = ent_rd_data.pkts + CTR_W'(1);
        ent_wr_data.bytes = ent_rd_data.bytes + CTR_W'(len_reg);
        if ((state_reg == ST_UPDATE) && !is_query_reg) begin
            if (hit) begin
                ent_wr_en = 1'b1;
            end else if (can_alloc) begin
                ent_wr_en         = 1'b1;
                map_wr_en         = 1'b1;
                ent_wr_addr       = alloc_reg[SLOT_W-1:0];
                ent_wr_data.pkts  = CTR_W'(1);
                ent_wr_data.bytes = CTR_W'(len_reg);
            end else begin
                drop_now = 1'b1;
            end
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    state_next = ((s_op == OP_QUERY) || counted_in) ? ST_MAP_RD : ST_DONE;
                end
            end
            ST_MAP_RD: state_next = ST_ENT_RD;
            ST_ENT_RD: state_next = ST_UPDATE;
            ST_UPDATE: state_next = src_pending_reg ? ST_MAP_RD : ST_DONE;
            ST_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            limit_reg   <= LIMIT_MAX;
            alloc_reg   <= '0;
            gpkts_reg   <= '0;
            gbytes_reg  <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (cfg_valid && cfg_ready) begin
                limit_reg <= cfg_data;
            end
            if (accept && counted_in) begin
                gpkts_reg  <= gpkts_reg + CTR_W'(1);
                gbytes_reg <= gbytes_reg + CTR_W'(s_total_length);
            end
            if (map_wr_en) begin
                alloc_reg <= alloc_reg + CNT_W'(1);
            end
            if ((state_reg == ST_DONE) && (!m_valid_reg || m_ready)) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // request payload and result accumulation
    always_ff @(posedge aclk) begin
        if (accept) begin
            is_query_reg    <= (s_op == OP_QUERY);
            len_reg         <= s_total_length;
            counted_reg     <= counted_in;
            ddrop_reg       <= 1'b0;
            sdrop_reg       <= 1'b0;
            found_reg       <= 1'b0;
            epk_reg         <= '0;
            eby_reg         <= '0;
            src_phase_reg   <= 1'b0;
            src_pending_reg <= counted_in && (s_source_port != s_destination_port);
            src_key_reg     <= {tr_in, s_source_port};
            cur_key_reg     <= (s_op == OP_QUERY) ? {s_query_is_udp, s_query_port}
                                                  : {tr_in, s_destination_port};
        end
        if (state_reg == ST_UPDATE) begin
            if (is_query_reg && hit) begin
                found_reg <= 1'b1;
                epk_reg   <= ent_rd_data.pkts;
                eby_reg   <= ent_rd_data.bytes;
            end
            if (drop_now) begin
                if (src_phase_reg) begin
                    sdrop_reg <= 1'b1;
                end else begin
                    ddrop_reg <= 1'b1;
                end
            end
            if (src_pending_reg) begin
                // second pass for the source port
                src_pending_reg <= 1'b0;
                src_phase_reg   <= 1'b1;
                cur_key_reg     <= src_key_reg;
            end
        end
        if ((state_reg == ST_DONE) && (!m_valid_reg || m_ready)) begin
            m_packet_counted      <= counted_reg;
            m_destination_dropped <= ddrop_reg;
            m_source_dropped      <= sdrop_reg;
            m_entries_in_use      <= alloc_reg;
            m_entry_found         <= found_reg;
            m_entry_packets       <= epk_reg;
            m_entry_bytes         <= eby_reg;
            m_all_packets         <= gpkts_reg;
            m_all_bytes           <= gbytes_reg;
        end
    end

endmodule
`default_nettype wire

### rtl/core/ptct_checker.sv
// port-level checks for the counter table, bound to the top level
// depends on ptct_pkg and port_traffic_counter_table_core
`default_nettype none
module ptct_port_checks
    import ptct_pkg::*;
(
    input wire logic             aclk,
    input wire logic             aresetn,
    input wire logic             s_valid,
    input wire logic             s_ready,
    input wire logic             m_valid,
    input wire logic             m_ready,
    input wire logic             m_packet_counted,
    input wire logic             m_destination_dropped,
    input wire logic             m_source_dropped,
    input wire logic [CNT_W-1:0] m_entries_in_use,
    input wire logic             m_entry_found
);
    a_result_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid)
        else $error("result dropped before taken");

    a_fill_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_entries_in_use <= LIMIT_MAX)
        else $error("fill count beyond table");

    a_drop_needs_count: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_destination_dropped || m_source_dropped) |-> m_packet_counted)
        else $error("drop flagged on uncounted request");

    a_query_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_entry_found |-> !m_packet_counted)
        else $error("query and packet flags together");

    a_no_ready_on_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("request taken back to back");
endmodule

bind port_traffic_counter_table_core ptct_port_checks u_ptct_port_checks (
    .aclk                  (aclk),
    .aresetn               (aresetn),
    .s_valid               (s_valid),
    .s_ready               (s_ready),
    .m_valid               (m_valid),
    .m_ready               (m_ready),
    .m_packet_counted      (m_packet_counted),
    .m_destination_dropped (m_destination_dropped),
    .m_source_dropped      (m_source_dropped),
    .m_entries_in_use      (m_entries_in_use),
    .m_entry_found         (m_entry_found)
);
`default_nettype wire
